// ----- rtl/izs_pkg.sv -----
`default_nettype none

package izs_pkg;

	// Zone storage limit; zone ids at or above it are never valid
	localparam int unsigned MAX_ZONES = 16;

	// Field widths
	localparam int unsigned ZONE_W  = 4;
	localparam int unsigned ML_W    = 24;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned TGT_W   = 26;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;

	// Milliseconds per second for the watering target
	localparam logic [9:0] MS_PER_SEC = 10'd1000;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_PRIME = 2'd1,
		MODE_WATER = 2'd2,
		MODE_FAULT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		F_NONE     = 3'd0,
		F_INVALID  = 3'd1,
		F_STALE    = 3'd2,
		F_LOWBAT   = 3'd3,
		F_LOWWATER = 3'd4,
		F_LOAD     = 3'd5,
		F_PRIME    = 3'd6,
		F_MAXDUR   = 3'd7
	} fault_t;

	typedef enum logic [2:0] {
		REQ_WATER = 3'd0,
		REQ_TICK  = 3'd1,
		REQ_CANCEL = 3'd2,
		REQ_CLEAR = 3'd3,
		REQ_TAKE  = 3'd4
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STALE_LIMIT  = 3'd0,
		CFG_MIN_SOC      = 3'd1,
		CFG_MIN_WATER    = 3'd2,
		CFG_PRIME_PULSES = 3'd3,
		CFG_PRIME_TMO    = 3'd4,
		CFG_MAX_DISPENSE = 3'd5,
		CFG_ZONE_COUNT   = 3'd6
	} cfg_idx_t;

	// A zone is valid below both the configured count and the storage limit
	function automatic logic zone_ok(input logic [ZONE_W-1:0] z, input logic [4:0] cnt);
		logic below_cnt;
		logic below_max;
		below_cnt = {1'b0, z} < cnt;
		below_max = 32'(z) < MAX_ZONES;
		return below_cnt && below_max;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/irrigation_zone_sequencer_core.sv -----
// Channel  | handshake                     | payload
// ---------+-------------------------------+-----------------------------------------
// input    | in_valid / in_stall           | req_type, now_ms, zone, ... flow_ml
// result   | out_valid / out_stall         | accepted, run_state, ... record_ml
// config   | cfg_we (no handshake back)    | cfg_index, cfg_data
//
// An item is taken into the input register and evaluated there against the sequencer
// state; its result loads into the output register when the input register advances,
// one item per cycle sustained while the result output is not stalled.
// A stalled result holds the input register, so in_stall rises only when both are full.
// arst_n clears the state machine, the delivery record, the valid flags and the configuration registers to defaults.
`default_nettype none

module irrigation_zone_sequencer_core import izs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input items
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           req_type,
	input  wire logic [TIME_W-1:0]    now_ms,
	input  wire logic [ZONE_W-1:0]    zone,
	input  wire logic [15:0]          duration_sec,
	input  wire logic                 sensor_valid,
	input  wire logic [TIME_W-1:0]    sensor_update_ms,
	input  wire logic [PCT_W-1:0]     battery_soc,
	input  wire logic [PCT_W-1:0]     tank_percent,
	input  wire logic                 load_ack,
	input  wire logic [23:0]          flow_pulses,
	input  wire logic [ML_W-1:0]      flow_ml,
	// result items
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      accepted,
	output logic [1:0]                run_state,
	output logic [2:0]                fault_code,
	output logic [ZONE_W-1:0]         active_zone,
	output logic                      zone_owned,
	output logic                      pump_on,
	output logic                      load_on,
	output logic                      flow_clear,
	output logic [ML_W-1:0]           delivered_ml,
	output logic                      record_valid,
	output logic [ZONE_W-1:0]         record_zone,
	output logic [ML_W-1:0]           record_ml
);

	// configuration registers
	logic [TIME_W-1:0] stale_limit_q;
	logic [PCT_W-1:0]  min_soc_q;
	logic [PCT_W-1:0]  min_water_q;
	logic [23:0]       prime_pulses_q;
	logic [TIME_W-1:0] prime_tmo_q;
	logic [TIME_W-1:0] max_dispense_q;
	logic [4:0]        zone_count_q;

	// input register
	logic              valid_s1;
	logic [2:0]        typ_s1;
	logic [TIME_W-1:0] now_s1;
	logic [ZONE_W-1:0] zone_s1;
	logic [15:0]       dur_s1;
	logic              svalid_s1;
	logic [TIME_W-1:0] supd_s1;
	logic [PCT_W-1:0]  soc_s1;
	logic [PCT_W-1:0]  tank_s1;
	logic              ack_s1;
	logic [23:0]       pulses_s1;
	logic [ML_W-1:0]   ml_s1;

	// sequencer state
	mode_t             mode_q, mode_d;
	fault_t            fault_q, fault_d;
	logic              owned_q, owned_d;
	logic [ZONE_W-1:0] cur_zone_q, cur_zone_d;
	logic [TIME_W-1:0] phase_start_q, phase_start_d;
	logic [TGT_W-1:0]  target_q, target_d;
	logic [ML_W-1:0]   last_ml_q, last_ml_d;
	logic              rec_pending_q, rec_pending_d;
	logic [ZONE_W-1:0] rec_zone_q, rec_zone_d;
	logic [ML_W-1:0]   rec_ml_q, rec_ml_d;

	// result register flags that are not part of the state
	logic              out_valid_q;
	logic              acc_q, acc_d;
	logic              fclr_q, fclr_d;

	logic              advance;
	logic              running;
	logic              aged;
	logic [TIME_W-1:0] elapsed;
	logic [TGT_W-1:0]  target_new;

	// hold the input register while a result waits behind a stalled output
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign advance  = valid_s1 && !(out_valid_q && out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q  <= 32'd60000;
			min_soc_q      <= 7'd20;
			min_water_q    <= 7'd10;
			prime_pulses_q <= 24'd20;
			prime_tmo_q    <= 32'd10000;
			max_dispense_q <= 32'd600000;
			zone_count_q   <= 5'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STALE_LIMIT:  stale_limit_q  <= cfg_data;
				CFG_MIN_SOC:      min_soc_q      <= cfg_data[PCT_W-1:0];
				CFG_MIN_WATER:    min_water_q    <= cfg_data[PCT_W-1:0];
				CFG_PRIME_PULSES: prime_pulses_q <= cfg_data[23:0];
				CFG_PRIME_TMO:    prime_tmo_q    <= cfg_data;
				CFG_MAX_DISPENSE: max_dispense_q <= cfg_data;
				CFG_ZONE_COUNT:   zone_count_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			typ_s1    <= req_type;
			now_s1    <= now_ms;
			zone_s1   <= zone;
			dur_s1    <= duration_sec;
			svalid_s1 <= sensor_valid;
			supd_s1   <= sensor_update_ms;
			soc_s1    <= battery_soc;
			tank_s1   <= tank_percent;
			ack_s1    <= load_ack;
			pulses_s1 <= flow_pulses;
			ml_s1     <= flow_ml;
		end
	end

	// shared terms of the event evaluation
	assign running    = (mode_q == MODE_PRIME) || (mode_q == MODE_WATER);
	assign elapsed    = now_s1 - phase_start_q;
	assign aged       = (supd_s1 != '0) && ((now_s1 - supd_s1) > stale_limit_q);
	assign target_new = TGT_W'(dur_s1) * TGT_W'(MS_PER_SEC);

	// evaluate one item against the state
	always_comb begin
		logic   do_cap;
		logic   go_fault;
		fault_t fcode;
		do_cap   = 1'b0;
		go_fault = 1'b0;
		fcode    = F_NONE;

		mode_d        = mode_q;
		fault_d       = fault_q;
		owned_d       = owned_q;
		cur_zone_d    = cur_zone_q;
		phase_start_d = phase_start_q;
		target_d      = target_q;
		last_ml_d     = last_ml_q;
		rec_pending_d = rec_pending_q;
		rec_zone_d    = rec_zone_q;
		rec_ml_d      = rec_ml_q;
		acc_d         = 1'b0;
		fclr_d        = 1'b0;

		case (typ_s1)
			REQ_WATER: begin
				if (mode_q == MODE_IDLE) begin
					owned_d = 1'b0;
					// checks in priority order; a failure leaves nothing delivered
					if (!zone_ok(zone_s1, zone_count_q) || dur_s1 == '0) begin
						fcode = F_INVALID;
					end else if (!svalid_s1 || aged) begin
						fcode = F_STALE;
					end else if (soc_s1 <= min_soc_q) begin
						fcode = F_LOWBAT;
					end else if (tank_s1 <= min_water_q) begin
						fcode = F_LOWWATER;
					end else if (!ack_s1) begin
						fcode = F_LOAD;
					end
					if (fcode != F_NONE) begin
						last_ml_d = '0;
						fault_d   = fcode;
						mode_d    = MODE_FAULT;
					end else begin
						cur_zone_d    = zone_s1;
						target_d      = target_new;
						last_ml_d     = '0;
						owned_d       = 1'b1;
						fclr_d        = 1'b1;
						phase_start_d = now_s1;
						mode_d        = MODE_PRIME;
						acc_d         = 1'b1;
					end
				end
			end
			REQ_TICK: begin
				if (mode_q == MODE_PRIME) begin
					if (pulses_s1 >= prime_pulses_q) begin
						phase_start_d = now_s1;
						mode_d        = MODE_WATER;
					end else if (elapsed >= prime_tmo_q) begin
						go_fault = 1'b1;
						fcode    = F_PRIME;
					end
				end else if (mode_q == MODE_WATER) begin
					if (elapsed >= max_dispense_q) begin
						go_fault = 1'b1;
						fcode    = F_MAXDUR;
					end else if (elapsed >= TIME_W'(target_q)) begin
						do_cap  = 1'b1;
						owned_d = 1'b0;
						mode_d  = MODE_IDLE;
					end else if (aged) begin
						go_fault = 1'b1;
						fcode    = F_STALE;
					end else if (soc_s1 <= min_soc_q) begin
						go_fault = 1'b1;
						fcode    = F_LOWBAT;
					end
				end
			end
			REQ_CANCEL: begin
				if (running) begin
					do_cap  = 1'b1;
					owned_d = 1'b0;
					mode_d  = MODE_IDLE;
				end
			end
			REQ_CLEAR: begin
				if (mode_q == MODE_FAULT) begin
					fault_d = F_NONE;
					owned_d = 1'b0;
					mode_d  = MODE_IDLE;
				end
			end
			REQ_TAKE: begin
				if (rec_pending_q) begin
					rec_pending_d = 1'b0;
					acc_d         = 1'b1;
				end
			end
			default: ;
		endcase

		// fault while running keeps the zone claimed until the fault is cleared
		if (go_fault) begin
			do_cap  = 1'b1;
			fault_d = fcode;
			mode_d  = MODE_FAULT;
		end

		// latch delivered volume and, for an owned valid zone, replace any pending record
		if (do_cap) begin
			if (owned_q || running) begin
				last_ml_d = ml_s1;
				if (owned_q && zone_ok(cur_zone_q, zone_count_q)) begin
					rec_zone_d    = cur_zone_q;
					rec_ml_d      = ml_s1;
					rec_pending_d = 1'b1;
				end
			end else begin
				last_ml_d = '0;
			end
		end
	end

	// state and result register, loaded as each item completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			fault_q       <= F_NONE;
			owned_q       <= 1'b0;
			cur_zone_q    <= '0;
			phase_start_q <= '0;
			target_q      <= '0;
			last_ml_q     <= '0;
			rec_pending_q <= 1'b0;
			rec_zone_q    <= '0;
			rec_ml_q      <= '0;
			acc_q         <= 1'b0;
			fclr_q        <= 1'b0;
		end else if (advance) begin
			mode_q        <= mode_d;
			fault_q       <= fault_d;
			owned_q       <= owned_d;
			cur_zone_q    <= cur_zone_d;
			phase_start_q <= phase_start_d;
			target_q      <= target_d;
			last_ml_q     <= last_ml_d;
			rec_pending_q <= rec_pending_d;
			rec_zone_q    <= rec_zone_d;
			rec_ml_q      <= rec_ml_d;
			acc_q         <= acc_d;
			fclr_q        <= fclr_d;
		end
	end

	// result valid: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	// result fields follow the state, which only moves when a new result loads
	assign out_valid    = out_valid_q;
	assign accepted     = acc_q;
	assign run_state    = mode_q;
	assign fault_code   = fault_q;
	assign active_zone  = owned_q ? cur_zone_q : '0;
	assign zone_owned   = owned_q;
	assign pump_on      = running;
	assign load_on      = running;
	assign flow_clear   = fclr_q;
	assign delivered_ml = last_ml_q;
	assign record_valid = rec_pending_q;
	assign record_zone  = rec_zone_q;
	assign record_ml    = rec_ml_q;

endmodule

`default_nettype wire

// ----- rtl/izs_checker.sv -----
`default_nettype none

module izs_checker import izs_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       accepted,
	input wire logic [1:0] run_state,
	input wire logic [2:0] fault_code,
	input wire logic       zone_owned,
	input wire logic       pump_on,
	input wire logic       load_on,
	input wire logic       flow_clear
);

	// pump and load run exactly while priming or watering
	a_run_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pump_on == load_on) &&
			(pump_on == (run_state == MODE_PRIME || run_state == MODE_WATER)))
		else $error("pump/load disagree with run state");

	// a fault code shows only in the fault state, and always there
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fault_code != F_NONE) == (run_state == MODE_FAULT)))
		else $error("fault code and run state disagree");

	// flow reset only on an accepted request that starts priming
	a_flow_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flow_clear |-> accepted && run_state == MODE_PRIME && zone_owned)
		else $error("flow clear without accepted request");

	// a running cycle always owns its zone
	a_run_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (run_state == MODE_PRIME || run_state == MODE_WATER) |-> zone_owned)
		else $error("running without an owned zone");

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(run_state) && $stable(accepted))
		else $error("stalled result changed");

endmodule

bind irrigation_zone_sequencer_core izs_checker u_izs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.accepted   (accepted),
	.run_state  (run_state),
	.fault_code (fault_code),
	.zone_owned (zone_owned),
	.pump_on    (pump_on),
	.load_on    (load_on),
	.flow_clear (flow_clear)
);

`default_nettype wire

// ----- test/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import izs_pkg::*;

	localparam int IDLE_PCT      = 33;
	localparam int HOLD_CYCLES   = 120;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 175;

	// Event codes outside the defined set, which the block must ignore
	localparam logic [2:0] REQ_BAD_FIRST = REQ_TAKE + 3'd1;
	localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] now;
		logic [3:0]  zone;
		logic [15:0] dur;
		logic        svalid;
		logic [31:0] supd;
		logic [6:0]  soc;
		logic [6:0]  tank;
		logic        ack;
		logic [23:0] pulses;
		logic [23:0] ml;
	} event_t;

	typedef struct packed {
		logic        acc;
		logic [1:0]  run;
		logic [2:0]  fault;
		logic [3:0]  azone;
		logic        owned;
		logic        pump;
		logic        load;
		logic        fclr;
		logic [23:0] delivered;
		logic        rvalid;
		logic [3:0]  rzone;
		logic [23:0] rml;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic out_valid;
	logic out_stall;
	event_t offered;

	logic accepted, zone_owned, pump_on, load_on, flow_clear, record_valid;
	logic [1:0] run_state;
	logic [2:0] fault_code;
	logic [ZONE_W-1:0] active_zone, record_zone;
	logic [ML_W-1:0] delivered_ml, record_ml;

	event_t pending_events[$];
	status_t expected_status[$];
	logic calm;
	logic hold_req;
	int hold_left = 0;
	int failures = 0;
	int results_seen = 0;
	int unsigned cycles = 0;
	logic [31:0] clock_ms;

	// Register copies
	logic [31:0] lim_stale;
	logic [6:0]  lim_min_soc;
	logic [6:0]  lim_min_water;
	logic [23:0] lim_prime_pulses;
	logic [31:0] lim_prime_tmo;
	logic [31:0] lim_max_dispense;
	logic [4:0]  lim_zones;

	// Sequencer state
	mode_t       seq_mode;
	fault_t      seq_fault;
	logic        seq_owned;
	logic [3:0]  seq_zone;
	logic [31:0] phase_start;
	logic [25:0] target_ms;
	logic [23:0] delivered;
	logic        rec_pending;
	logic [3:0]  rec_zone;
	logic [23:0] rec_ml;

	irrigation_zone_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(offered.kind),
		.now_ms(offered.now),
		.zone(offered.zone),
		.duration_sec(offered.dur),
		.sensor_valid(offered.svalid),
		.sensor_update_ms(offered.supd),
		.battery_soc(offered.soc),
		.tank_percent(offered.tank),
		.load_ack(offered.ack),
		.flow_pulses(offered.pulses),
		.flow_ml(offered.ml),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.run_state(run_state),
		.fault_code(fault_code),
		.active_zone(active_zone),
		.zone_owned(zone_owned),
		.pump_on(pump_on),
		.load_on(load_on),
		.flow_clear(flow_clear),
		.delivered_ml(delivered_ml),
		.record_valid(record_valid),
		.record_zone(record_zone),
		.record_ml(record_ml)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic zone_valid(logic [3:0] z);
		return ({1'b0, z} < lim_zones) && (int'(z) < MAX_ZONES);
	endfunction

	// Latch delivered volume; make a record while a valid zone is owned
	function automatic void latch_delivery(logic [23:0] ml);
		if (!(seq_owned || seq_mode == MODE_PRIME || seq_mode == MODE_WATER)) begin
			delivered = '0;
		end else begin
			delivered = ml;
			if (seq_owned && zone_valid(seq_zone)) begin
				rec_zone = seq_zone;
				rec_ml = ml;
				rec_pending = 1'b1;
			end
		end
	endfunction

	function automatic void enter_fault(fault_t code, logic [23:0] ml);
		latch_delivery(ml);
		seq_fault = code;
		seq_mode = MODE_FAULT;
	endfunction

	// Advance the sequencer by one event and return the status it shows
	function automatic status_t sequencer_step(event_t ev);
		status_t r;
		logic acc;
		logic fclr;
		logic aged;
		logic running;
		logic [31:0] age;
		logic [31:0] elapsed;
		acc = 1'b0;
		fclr = 1'b0;
		age = ev.now - ev.supd;
		aged = (ev.supd != '0) && (age > lim_stale);
		elapsed = ev.now - phase_start;
		case (ev.kind)
			REQ_WATER: begin
				if (seq_mode == MODE_IDLE) begin
					seq_owned = 1'b0;
					if (!zone_valid(ev.zone) || ev.dur == '0) begin
						enter_fault(F_INVALID, ev.ml);
					end else if (!ev.svalid || aged) begin
						enter_fault(F_STALE, ev.ml);
					end else if (ev.soc <= lim_min_soc) begin
						enter_fault(F_LOWBAT, ev.ml);
					end else if (ev.tank <= lim_min_water) begin
						enter_fault(F_LOWWATER, ev.ml);
					end else if (!ev.ack) begin
						enter_fault(F_LOAD, ev.ml);
					end else begin
						seq_zone = ev.zone;
						target_ms = 26'(ev.dur) * 26'(MS_PER_SEC);
						delivered = '0;
						seq_owned = 1'b1;
						fclr = 1'b1;
						phase_start = ev.now;
						seq_mode = MODE_PRIME;
						acc = 1'b1;
					end
				end
			end
			REQ_TICK: begin
				if (seq_mode == MODE_PRIME) begin
					if (ev.pulses >= lim_prime_pulses) begin
						phase_start = ev.now;
						seq_mode = MODE_WATER;
					end else if (elapsed >= lim_prime_tmo) begin
						enter_fault(F_PRIME, ev.ml);
					end
				end else if (seq_mode == MODE_WATER) begin
					if (elapsed >= lim_max_dispense) begin
						enter_fault(F_MAXDUR, ev.ml);
					end else if (elapsed >= {6'd0, target_ms}) begin
						latch_delivery(ev.ml);
						seq_owned = 1'b0;
						seq_mode = MODE_IDLE;
					end else if (aged) begin
						enter_fault(F_STALE, ev.ml);
					end else if (ev.soc <= lim_min_soc) begin
						enter_fault(F_LOWBAT, ev.ml);
					end
				end
			end
			REQ_CANCEL: begin
				if (seq_mode == MODE_PRIME || seq_mode == MODE_WATER) begin
					latch_delivery(ev.ml);
					seq_owned = 1'b0;
					seq_mode = MODE_IDLE;
				end
			end
			REQ_CLEAR: begin
				if (seq_mode == MODE_FAULT) begin
					seq_fault = F_NONE;
					seq_owned = 1'b0;
					seq_mode = MODE_IDLE;
				end
			end
			REQ_TAKE: begin
				if (rec_pending) begin
					rec_pending = 1'b0;
					acc = 1'b1;
				end
			end
			default: ;
		endcase
		running = (seq_mode == MODE_PRIME || seq_mode == MODE_WATER);
		r.acc = acc;
		r.run = seq_mode;
		r.fault = seq_fault;
		r.azone = seq_owned ? seq_zone : 4'd0;
		r.owned = seq_owned;
		r.pump = running;
		r.load = running;
		r.fclr = fclr;
		r.delivered = delivered;
		r.rvalid = rec_pending;
		r.rzone = rec_zone;
		r.rml = rec_ml;
		return r;
	endfunction

	function automatic string show(status_t s);
		return $sformatf({"acc=%0b run=%0d fault=%0d zone=%0d owned=%0b pump=%0b load=%0b ",
			"clr=%0b dlv=%0d rec=%0b/%0d/%0d"}, s.acc, s.run, s.fault, s.azone, s.owned,
			s.pump, s.load, s.fclr, s.delivered, s.rvalid, s.rzone, s.rml);
	endfunction

	// Event with sensors in good order at the current time
	function automatic event_t healthy(logic [2:0] kind);
		event_t ev;
		int unsigned zmax;
		zmax = (lim_zones == 0) ? 0 : ((lim_zones > MAX_ZONES) ? MAX_ZONES - 1 : lim_zones - 1);
		ev.kind = kind;
		ev.now = clock_ms;
		ev.zone = 4'($urandom_range(0, zmax));
		ev.dur = 16'($urandom_range(1, 8));
		ev.svalid = 1'b1;
		ev.supd = clock_ms - $urandom_range(0, (lim_stale < 2000) ? lim_stale : 2000);
		ev.soc = (lim_min_soc >= 100) ? 7'd100 : 7'($urandom_range(lim_min_soc + 1, 100));
		ev.tank = (lim_min_water >= 100) ? 7'd100 : 7'($urandom_range(lim_min_water + 1, 100));
		ev.ack = 1'b1;
		ev.pulses = 24'($urandom);
		ev.ml = 24'($urandom);
		return ev;
	endfunction

	// Sensor time stamp older than the stale limit
	function automatic logic [31:0] old_stamp();
		return clock_ms - lim_stale - 32'd1 - 32'($urandom_range(0, 999));
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_STALE_LIMIT:  lim_stale = val;
			CFG_MIN_SOC:      lim_min_soc = val[6:0];
			CFG_MIN_WATER:    lim_min_water = val[6:0];
			CFG_PRIME_PULSES: lim_prime_pulses = val[23:0];
			CFG_PRIME_TMO:    lim_prime_tmo = val;
			CFG_MAX_DISPENSE: lim_max_dispense = val;
			CFG_ZONE_COUNT:   lim_zones = val[4:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] stale, soc, water, pulses, ptmo, maxd, zones);
		write_reg(CFG_STALE_LIMIT, stale);
		write_reg(CFG_MIN_SOC, soc);
		write_reg(CFG_MIN_WATER, water);
		write_reg(CFG_PRIME_PULSES, pulses);
		write_reg(CFG_PRIME_TMO, ptmo);
		write_reg(CFG_MAX_DISPENSE, maxd);
		write_reg(CFG_ZONE_COUNT, zones);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every queued item has gone in and every result has come out
	task automatic wait_drained();
		@(negedge clk);
		while (pending_events.size() != 0 || in_valid || expected_status.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One watering cycle: housekeeping, a request, then ticks with rising flow
	task automatic add_watering_cycle(output int added);
		event_t ev;
		int ticks;
		logic [23:0] pulses;
		logic [23:0] ml;
		added = 0;
		clock_ms += $urandom_range(1, 4000);
		pending_events.push_back(healthy(REQ_CANCEL));
		pending_events.push_back(healthy(REQ_CLEAR));
		added += 2;
		if ($urandom_range(0, 2) == 0) begin
			pending_events.push_back(healthy(REQ_TAKE));
			added++;
		end
		ev = healthy(REQ_WATER);
		case ($urandom_range(0, 19))
			0: ev.zone = 4'($urandom);
			1: ev.dur = '0;
			2: ev.svalid = 1'b0;
			3: ev.supd = old_stamp();
			4: ev.soc = 7'($urandom_range(0, lim_min_soc));
			5: ev.tank = 7'($urandom_range(0, lim_min_water));
			6: ev.ack = 1'b0;
			7: ev.dur = 16'($urandom);
			default: ;
		endcase
		pending_events.push_back(ev);
		added++;
		ticks = $urandom_range(1, 14);
		pulses = '0;
		ml = '0;
		repeat (ticks) begin
			clock_ms += $urandom_range(0, 1500);
			pulses += 24'($urandom_range(0, 12));
			ml += 24'($urandom_range(0, 900));
			ev = healthy(REQ_TICK);
			ev.pulses = pulses;
			ev.ml = ml;
			case ($urandom_range(0, 29))
				0: ev.kind = REQ_CANCEL;
				1: ev.soc = 7'($urandom_range(0, lim_min_soc));
				2: ev.supd = old_stamp();
				3: ev.kind = REQ_TAKE;
				4: ev.kind = REQ_WATER;
				default: ;
			endcase
			pending_events.push_back(ev);
			added++;
		end
	endtask

	// Fully random event
	function automatic event_t noise();
		event_t ev;
		ev.kind = 3'($urandom_range(0, 7));
		ev.now = $urandom;
		ev.zone = 4'($urandom);
		ev.dur = 16'($urandom);
		ev.svalid = 1'($urandom);
		ev.supd = $urandom;
		ev.soc = 7'($urandom_range(0, 100));
		ev.tank = 7'($urandom_range(0, 100));
		ev.ack = 1'($urandom);
		ev.pulses = 24'($urandom);
		ev.ml = 24'($urandom);
		return ev;
	endfunction

	// Offer queued items; predict each one as it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_status.push_back(sequencer_step(offered));
			if (!in_valid || !in_stall) begin
				if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					offered <= pending_events.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
	end

	// Compare each result taken with the oldest expectation
	always @(posedge clk) begin : check_results
		status_t seen;
		status_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {accepted, run_state, fault_code, active_zone, zone_owned, pump_on, load_on,
				flow_clear, delivered_ml, record_valid, record_zone, record_ml};
			if (expected_status.size() == 0) begin
				if (failures < 10)
					$display("result %0d with nothing expected: %s", results_seen, show(seen));
				failures++;
			end else begin
				want = expected_status.pop_front();
				if (seen !== want) begin
					if (failures < 10) begin
						$display("result %0d mismatch", results_seen);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(seen));
					end
					failures++;
				end
			end
			results_seen++;
		end
		out_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < IDLE_PCT);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		event_t ev;
		int added;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_STALE_LIMIT;
		cfg_data = '0;
		offered = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		lim_stale = 32'd60000;
		lim_min_soc = 7'd20;
		lim_min_water = 7'd10;
		lim_prime_pulses = 24'd20;
		lim_prime_tmo = 32'd10000;
		lim_max_dispense = 32'd600000;
		lim_zones = 5'd4;
		seq_mode = MODE_IDLE;
		seq_fault = F_NONE;
		seq_owned = 1'b0;
		seq_zone = '0;
		phase_start = '0;
		target_ms = '0;
		delivered = '0;
		rec_pending = 1'b0;
		rec_zone = '0;
		rec_ml = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: events outside their states, each request check, one record
		clock_ms = 32'd100000;
		pending_events.push_back(healthy(REQ_TAKE));
		ev = healthy(REQ_TICK);
		ev.kind = REQ_BAD_LAST;
		pending_events.push_back(ev);
		ev.kind = REQ_BAD_FIRST;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_TICK));
		pending_events.push_back(healthy(REQ_CANCEL));
		ev = healthy(REQ_WATER);
		ev.zone = 4'd15;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_WATER));
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.dur = '0;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.svalid = 1'b0;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.supd = old_stamp();
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.soc = lim_min_soc;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.tank = lim_min_water;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.ack = 1'b0;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.zone = 4'd3;
		ev.dur = 16'hFFFF;
		ev.supd = '0;
		pending_events.push_back(ev);
		clock_ms += 32'd600;
		ev = healthy(REQ_TICK);
		ev.pulses = lim_prime_pulses;
		pending_events.push_back(ev);
		clock_ms += 32'd100;
		ev = healthy(REQ_TICK);
		ev.supd = old_stamp();
		ev.ml = 24'hFFFFFF;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_TAKE));
		pending_events.push_back(healthy(REQ_CLEAR));
		wait_drained();

		// Loosest limits, time wrapping through zero, record replaced before take
		apply_settings(32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF, 32'd16);
		clock_ms = 32'hFFFFFE00;
		ev = healthy(REQ_WATER);
		ev.zone = 4'd15;
		ev.dur = 16'd1;
		ev.supd = 32'd1;
		pending_events.push_back(ev);
		ev = healthy(REQ_TICK);
		ev.pulses = '0;
		pending_events.push_back(ev);
		clock_ms = clock_ms + 32'(MS_PER_SEC) - 32'd1;
		pending_events.push_back(healthy(REQ_TICK));
		clock_ms += 32'd1;
		pending_events.push_back(healthy(REQ_TICK));
		ev = healthy(REQ_WATER);
		ev.zone = 4'd2;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CANCEL));
		pending_events.push_back(healthy(REQ_TAKE));
		pending_events.push_back(healthy(REQ_TAKE));
		wait_drained();

		// Tightest limits: nothing passes the charge check, zero age limit
		apply_settings(32'd0, 32'd100, 32'd100, 32'hFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd1);
		clock_ms = $urandom;
		ev = healthy(REQ_WATER);
		ev.supd = clock_ms;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.supd = clock_ms - 32'd1;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		wait_drained();

		// Zero timeouts: prime timeout, then hard limit on the first watering tick
		apply_settings(32'd0, 32'd0, 32'd0, 32'hFFFFFF, 32'd0, 32'd0, 32'd1);
		ev = healthy(REQ_WATER);
		ev.zone = 4'd1;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.supd = clock_ms;
		pending_events.push_back(ev);
		ev = healthy(REQ_TICK);
		ev.pulses = 24'hFFFFFE;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CANCEL));
		pending_events.push_back(healthy(REQ_TICK));
		pending_events.push_back(healthy(REQ_CLEAR));
		ev = healthy(REQ_WATER);
		ev.supd = '0;
		pending_events.push_back(ev);
		ev = healthy(REQ_TICK);
		ev.pulses = 24'hFFFFFF;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_TICK));
		pending_events.push_back(healthy(REQ_CLEAR));
		pending_events.push_back(healthy(REQ_TAKE));
		wait_drained();

		// Zone count of zero: no zone valid
		apply_settings(32'd60000, 32'd20, 32'd10, 32'd20, 32'd10000, 32'd600000, 32'd0);
		pending_events.push_back(healthy(REQ_WATER));
		pending_events.push_back(healthy(REQ_CLEAR));
		wait_drained();

		// Zone count beyond the storage limit: top zone id valid
		apply_settings(32'd60000, 32'd20, 32'd10, 32'd20, 32'd10000, 32'd600000, 32'd31);
		ev = healthy(REQ_WATER);
		ev.zone = 4'd15;
		pending_events.push_back(ev);
		pending_events.push_back(healthy(REQ_CANCEL));
		pending_events.push_back(healthy(REQ_TAKE));
		wait_drained();

		// Random phases: mostly full watering cycles, some noise
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			apply_settings($urandom_range(3000, 60000), $urandom_range(0, 40),
				$urandom_range(0, 30), $urandom_range(1, 40), $urandom_range(500, 8000),
				$urandom_range(2000, 15000), $urandom_range(1, 16));
			calm = (ph == 1);
			clock_ms = $urandom;
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 7) == 0) begin
					pending_events.push_back(noise());
					n++;
				end else begin
					add_watering_cycle(added);
					n += added;
				end
			end
			// Stall the results long enough to back up the input
			if (ph == 3) begin
				@(negedge clk);
				hold_req = 1'b1;
				@(negedge clk);
				hold_req = 1'b0;
			end
			wait_drained();
			calm = 1'b0;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
